// ----- src/bbc_pkg.sv -----
// bracket balance checker: shared constants, codes and item types
// no dependencies; imported by every module of the block
`default_nettype none

package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int MAX_TOKENS  = 1024;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 10;
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W   = $clog2(STACK_DEPTH);

	// token index saturates here
	localparam int POS_TOP_INT = ((MAX_TOKENS - 1) < 1023) ? (MAX_TOKENS - 1) : 1023;
	localparam logic [POS_W-1:0] POS_TOP  = POS_W'(POS_TOP_INT);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		TK_OTHER        = 3'd0,
		TK_OPEN_SQUARE  = 3'd1,
		TK_OPEN_CURLY   = 3'd2,
		TK_OPEN_ROUND   = 3'd3,
		TK_CLOSE_SQUARE = 3'd4,
		TK_CLOSE_CURLY  = 3'd5,
		TK_CLOSE_ROUND  = 3'd6
	} tok_t;

	typedef enum logic [1:0] {
		BRK_NONE   = 2'd0,
		BRK_SQUARE = 2'd1,
		BRK_CURLY  = 2'd2,
		BRK_ROUND  = 2'd3
	} brk_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BALANCED   = 3'd0,
		ST_BAD_SQUARE = 3'd1,
		ST_BAD_CURLY  = 3'd2,
		ST_BAD_ROUND  = 3'd3,
		ST_TOO_DEEP   = 3'd4
	} status_t;

	// classified token, front to back
	typedef struct packed {
		op_t  op;
		brk_t brk;
		logic starts;
		logic ends;
	} cmd_t;

	// one open-bracket stack entry
	typedef struct packed {
		brk_t             brk;
		logic [POS_W-1:0] pos;
	} entry_t;

	// one result item
	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] open_pos;
		logic [POS_W-1:0] close_pos;
	} res_t;

endpackage

`default_nettype wire

// ----- src/bbc_front.sv -----
// bracket balance checker front: input handshake, token classification
// and a two-entry command queue towards the stack engine; uses bbc_pkg
`default_nettype none

module bbc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bbc_pkg::KIND_W-1:0] token_kind,
	input  wire logic                       starts_statement,
	input  wire logic                       ends_statement,
	input  wire logic                       push,
	output logic                            full,
	output bbc_pkg::cmd_t                   cmd,
	output logic                            cmd_valid,
	input  wire logic                       cmd_take
);
	import bbc_pkg::*;

	cmd_t       dec;
	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	// classify the token kind; unused kind counts as other
	always_comb begin
		dec.starts = starts_statement;
		dec.ends   = ends_statement;
		case (token_kind) inside
			[TK_OPEN_SQUARE:TK_OPEN_ROUND]:   dec.op = OP_OPEN;
			[TK_CLOSE_SQUARE:TK_CLOSE_ROUND]: dec.op = OP_CLOSE;
			default:                          dec.op = OP_NONE;
		endcase
		case (token_kind) inside
			TK_OPEN_SQUARE, TK_CLOSE_SQUARE: dec.brk = BRK_SQUARE;
			TK_OPEN_CURLY, TK_CLOSE_CURLY:   dec.brk = BRK_CURLY;
			TK_OPEN_ROUND, TK_CLOSE_ROUND:   dec.brk = BRK_ROUND;
			default:                         dec.brk = BRK_NONE;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/bbc_exec.sv -----
// bracket balance checker back: stack engine with the open-bracket memory,
// token numbering and error mark; uses bbc_pkg
`default_nettype none

module bbc_exec (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bbc_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_take,
	output bbc_pkg::res_t      res,
	output logic               res_push,
	input  wire logic          res_ready
);
	import bbc_pkg::*;

	entry_t             stack_mem [STACK_DEPTH];
	entry_t             top_q;
	entry_t             below_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   idx_q;
	logic               err_q;

	logic               fire;
	logic [CNT_W-1:0]   cnt_base;
	logic               err_base;
	logic [POS_W-1:0]   pos;
	logic [CNT_W-1:0]   cnt_d;
	logic [POS_W-1:0]   idx_d;
	logic               err_d;
	entry_t             top_d;
	logic               wr_en;
	entry_t             wr_entry;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CNT_W-1:0]   rd_cnt;
	logic               produced;

	assign fire     = cmd_valid && res_ready;
	assign cmd_take = fire;

	always_comb begin
		cnt_base = cmd.starts ? '0 : cnt_q;
		err_base = cmd.starts ? 1'b0 : err_q;
		pos      = cmd.starts ? '0 : idx_q;

		cnt_d    = cnt_q;
		idx_d    = idx_q;
		err_d    = err_q;
		top_d    = top_q;
		wr_en    = 1'b0;
		wr_entry = '{brk: cmd.brk, pos: pos};
		wr_addr  = cnt_base[ADDR_W-1:0];
		produced = 1'b0;
		res      = '{status: ST_BALANCED, open_pos: '0, close_pos: '0};

		if (fire) begin
			cnt_d = cnt_base;
			err_d = err_base;
			idx_d = (pos < POS_TOP) ? pos + 1'b1 : pos;
			if (!err_base) begin
				case (cmd.op)
					OP_OPEN: begin
						if (cnt_base == CNT_FULL) begin
							err_d    = 1'b1;
							produced = 1'b1;
							res      = '{status: ST_TOO_DEEP, open_pos: pos, close_pos: pos};
						end else begin
							wr_en = 1'b1;
							top_d = wr_entry;
							cnt_d = cnt_base + 1'b1;
						end
					end
					OP_CLOSE: begin
						if (cnt_base != '0 && top_q.brk == cmd.brk) begin
							top_d = below_q;
							cnt_d = cnt_base - 1'b1;
						end else begin
							err_d        = 1'b1;
							produced     = 1'b1;
							res.status   = status_t'({1'b0, cmd.brk});
							res.open_pos = (cnt_base != '0) ? top_q.pos : pos;
							res.close_pos = pos;
						end
					end
					default: begin
					end
				endcase
				if (cmd.ends && !err_d) begin
					produced = 1'b1;
				end
			end
		end
	end

	assign res_push = fire && produced;

	// keep the entry below the new top prefetched
	assign rd_cnt  = cnt_d - CNT_W'(2);
	assign rd_addr = rd_cnt[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_entry;
		end
		below_q <= stack_mem[rd_addr];
		top_q   <= top_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			err_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			err_q <= err_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("stack count beyond depth");

	a_idx_sat: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= POS_TOP)
		else $error("token index beyond saturation point");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fire && err_q && !cmd.starts |-> !res_push && cnt_d == cnt_q && err_d)
		else $error("item after an error changed state or gave a result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_ready)
		else $error("result pushed into a full queue");

	a_err_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.status != ST_BALANCED |=> err_q)
		else $error("error result without error mark");

endmodule

`default_nettype wire

// ----- src/bbc_resq.sv -----
// bracket balance checker result queue: two-entry queue between the stack
// engine and the result ports; uses bbc_pkg
`default_nettype none

module bbc_resq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bbc_pkg::res_t                res,
	input  wire logic                         res_push,
	output logic                              res_ready,
	output logic [bbc_pkg::STATUS_W-1:0]      status,
	output logic [bbc_pkg::POS_W-1:0]         open_position,
	output logic [bbc_pkg::POS_W-1:0]         close_position,
	output logic                              empty,
	input  wire logic                         pop
);
	import bbc_pkg::*;

	res_t       ent_q [2];
	res_t       head;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign do_push   = res_push && res_ready;
	assign do_pop    = pop && !empty;

	assign head           = ent_q[rd_ptr_q];
	assign status         = head.status;
	assign open_position  = head.open_pos;
	assign close_position = head.close_pos;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/bracket_balance_checker_top.sv -----
// bracket balance checker top level: front, stack engine and result queue
// depends on bbc_pkg, bbc_front, bbc_exec and bbc_resq
`default_nettype none

// channel   | handshake        | accepted when         | payload
// ----------+------------------+-----------------------+-------------------------------------
// token in  | push / full      | push && !full         | token_kind, starts_statement,
//           |                  |                       | ends_statement
// result    | empty / pop      | pop && !empty         | status, open_position, close_position
//
// cycles: one token item per clock sustained while the result queue has room; the engine
//   handles one item per cycle, reading only the prefetched entry below the top of stack
// path: tokens are registered in the command queue, results in the result queue
// reset: clears pointers, counts, token index and error mark, not the stack memory
// stalls: a held-off pop fills the result queue, the engine then stops taking
//   items and the two-entry command queue raises full

module bracket_balance_checker_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [bbc_pkg::KIND_W-1:0]   token_kind,
	input  wire logic                         starts_statement,
	input  wire logic                         ends_statement,
	input  wire logic                         push,
	output logic                              full,
	output logic [bbc_pkg::STATUS_W-1:0]      status,
	output logic [bbc_pkg::POS_W-1:0]         open_position,
	output logic [bbc_pkg::POS_W-1:0]         close_position,
	output logic                              empty,
	input  wire logic                         pop
);
	import bbc_pkg::*;

	// classified token items waiting for the engine
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	// result items from the engine
	res_t res;
	logic res_push;
	logic res_ready;

	// front: classify each token and queue it
	bbc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.token_kind       (token_kind),
		.starts_statement (starts_statement),
		.ends_statement   (ends_statement),
		.push             (push),
		.full             (full),
		.cmd              (cmd),
		.cmd_valid        (cmd_valid),
		.cmd_take         (cmd_take)
	);

	// back: bracket stack, token numbering, first-error detection
	bbc_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.res       (res),
		.res_push  (res_push),
		.res_ready (res_ready)
	);

	// output register pair, so a waiting result does not block new tokens
	bbc_resq u_resq (
		.clk            (clk),
		.arst_n         (arst_n),
		.res            (res),
		.res_push       (res_push),
		.res_ready      (res_ready),
		.status         (status),
		.open_position  (open_position),
		.close_position (close_position),
		.empty          (empty),
		.pop            (pop)
	);

endmodule

`default_nettype wire

// ----- test/bbc_checker.sv -----
`timescale 1ns / 100ps
// bracket nesting predictor and result scoreboard for the bracket balance checker
// depends on bbc_pkg; instantiated beside the block by tb_bracket_balance_checker_top

module bbc_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [bbc_pkg::KIND_W-1:0]   token_kind,
	input  wire logic                         starts_statement,
	input  wire logic                         ends_statement,
	input  wire logic                         push,
	input  wire logic                         full,
	input  wire logic [bbc_pkg::STATUS_W-1:0] status,
	input  wire logic [bbc_pkg::POS_W-1:0]    open_position,
	input  wire logic [bbc_pkg::POS_W-1:0]    close_position,
	input  wire logic                         empty,
	input  wire logic                         pop,
	output int                                fail_count,
	output int                                pending
);
	import bbc_pkg::*;

	// predicted nesting state
	entry_t           open_brackets [STACK_DEPTH];
	int               depth_now;
	logic [POS_W-1:0] next_index;
	bit               in_error;

	res_t awaited_status [$];

	task automatic report(input string what, input int got, input int want);
		$display("%0t bbc_checker: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic bracket_step(input logic [KIND_W-1:0] kind, input logic s, input logic e);
		logic [POS_W-1:0] here;
		brk_t             opened;
		brk_t             closes;
		status_t          bad;
		res_t             r;
		if (s) begin
			depth_now  = 0;
			next_index = '0;
			in_error   = 1'b0;
		end
		here = next_index;
		if (next_index < POS_TOP)
			next_index++;
		if (!in_error) begin
			opened = BRK_NONE;
			closes = BRK_NONE;
			bad    = ST_BALANCED;
			case (kind)
				TK_OPEN_SQUARE:  opened = BRK_SQUARE;
				TK_OPEN_CURLY:   opened = BRK_CURLY;
				TK_OPEN_ROUND:   opened = BRK_ROUND;
				TK_CLOSE_SQUARE: begin
					closes = BRK_SQUARE;
					bad    = ST_BAD_SQUARE;
				end
				TK_CLOSE_CURLY: begin
					closes = BRK_CURLY;
					bad    = ST_BAD_CURLY;
				end
				TK_CLOSE_ROUND: begin
					closes = BRK_ROUND;
					bad    = ST_BAD_ROUND;
				end
				default: ;
			endcase
			if (opened != BRK_NONE) begin
				if (depth_now >= STACK_DEPTH) begin
					in_error    = 1'b1;
					r.status    = ST_TOO_DEEP;
					r.open_pos  = here;
					r.close_pos = here;
					awaited_status.insert(awaited_status.size(), r);
				end else begin
					open_brackets[depth_now].brk = opened;
					open_brackets[depth_now].pos = here;
					depth_now++;
				end
			end else if (closes != BRK_NONE) begin
				if (depth_now > 0 && open_brackets[depth_now-1].brk == closes) begin
					depth_now--;
				end else begin
					in_error    = 1'b1;
					r.status    = bad;
					r.open_pos  = (depth_now > 0) ? open_brackets[depth_now-1].pos : here;
					r.close_pos = here;
					awaited_status.insert(awaited_status.size(), r);
				end
			end
			if (e && !in_error) begin
				r.status    = ST_BALANCED;
				r.open_pos  = '0;
				r.close_pos = '0;
				awaited_status.insert(awaited_status.size(), r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			depth_now  = 0;
			next_index = '0;
			in_error   = 1'b0;
			awaited_status.delete();
			pending = 0;
		end else begin
			if (push && !full)
				bracket_step(token_kind, starts_statement, ends_statement);
			if (pop && !empty) begin
				if (awaited_status.size() == 0) begin
					report("unexpected result, status", status, -1);
				end else begin
					want = awaited_status.pop_front();
					if (status != want.status)
						report("status", status, want.status);
					if (open_position != want.open_pos)
						report("open_position", open_position, want.open_pos);
					if (close_position != want.close_pos)
						report("close_position", close_position, want.close_pos);
				end
			end
			pending = awaited_status.size();
		end
	end

endmodule

// ----- test/tb_bracket_balance_checker_top.sv -----
`timescale 1ns / 100ps
// token stimulus and verdict for the bracket balance checker top level
// depends on bbc_pkg, bracket_balance_checker_top and bbc_checker

module tb_bracket_balance_checker_top;
	import bbc_pkg::*;

	// unused token code, the block treats it as an ordinary token
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 80;

	logic                clk;
	logic                arst_n = 1'b0;
	logic [KIND_W-1:0]   token_kind = '0;
	logic                starts_statement = 1'b0;
	logic                ends_statement = 1'b0;
	logic                push = 1'b0;
	logic                pop = 1'b0;
	logic                full;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    open_position;
	logic [POS_W-1:0]    close_position;
	logic                empty;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// sender pacing
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int items_sent = 0;

	// long receiver hold-off, raised by the sender and counted by the receiver
	bit hold_req = 1'b0;

	// statement under construction and the openers it leaves open
	logic [KIND_W-1:0] stmt_kinds [$];
	tok_t              open_track [$];

	bracket_balance_checker_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.token_kind       (token_kind),
		.starts_statement (starts_statement),
		.ends_statement   (ends_statement),
		.push             (push),
		.full             (full),
		.status           (status),
		.open_position    (open_position),
		.close_position   (close_position),
		.empty            (empty),
		.pop              (pop)
	);

	bbc_checker scoreboard (
		.clk              (clk),
		.arst_n           (arst_n),
		.token_kind       (token_kind),
		.starts_statement (starts_statement),
		.ends_statement   (ends_statement),
		.push             (push),
		.full             (full),
		.status           (status),
		.open_position    (open_position),
		.close_position   (close_position),
		.empty            (empty),
		.pop              (pop),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hang or a lost result ends here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_bracket_balance_checker_top: errors");
		$finish;
	end

	// receiver: pop pattern changes every segment, with one long hold-off on request
	initial begin : receiver
		int hold_left;
		int seg_left;
		int mode;
		bit hold_taken;
		hold_left = 0;
		seg_left = 0;
		mode = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 80);
				end
				seg_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 3) != 0);
					default: pop <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// offer one item and hold it until the block takes it; gaps fall between bursts
	task automatic put_token(input logic [KIND_W-1:0] k, input logic s, input logic e);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
				token_kind <= KIND_W'($urandom);
				starts_statement <= 1'($urandom);
				ends_statement <= 1'($urandom);
			end
		end
		@(negedge clk);
		token_kind <= k;
		starts_statement <= s;
		ends_statement <= e;
		push <= 1'b1;
		do @(posedge clk); while (full);
		burst_left--;
		items_sent++;
	endtask

	// stop offering and wait until every predicted result has been popped
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic tok_t closer_for(input tok_t opener);
		case (opener)
			TK_OPEN_SQUARE: return TK_CLOSE_SQUARE;
			TK_OPEN_CURLY:  return TK_CLOSE_CURLY;
			default:        return TK_CLOSE_ROUND;
		endcase
	endfunction

	function automatic tok_t random_opener();
		case ($urandom_range(0, 2))
			0:       return TK_OPEN_SQUARE;
			1:       return TK_OPEN_CURLY;
			default: return TK_OPEN_ROUND;
		endcase
	endfunction

	function automatic tok_t random_closer();
		return closer_for(random_opener());
	endfunction

	function automatic logic [KIND_W-1:0] random_other();
		return ($urandom_range(0, 9) == 0) ? KIND_UNUSED : TK_OTHER;
	endfunction

	// take the innermost opener off the tracking list
	function automatic tok_t take_last_open();
		tok_t o;
		o = open_track[$];
		open_track.delete(open_track.size() - 1);
		return o;
	endfunction

	// random well-nested content; openers may be left open when close_all is clear
	task automatic build_balanced(input int len, input int max_depth, input bit close_all);
		int r;
		tok_t o;
		stmt_kinds.delete();
		open_track.delete();
		repeat (len) begin
			r = $urandom_range(0, 2);
			if (r == 1 && open_track.size() < max_depth) begin
				o = random_opener();
				open_track.insert(open_track.size(), o);
				stmt_kinds.insert(stmt_kinds.size(), o);
			end else if (r == 2 && open_track.size() > 0) begin
				stmt_kinds.insert(stmt_kinds.size(), closer_for(take_last_open()));
			end else begin
				stmt_kinds.insert(stmt_kinds.size(), random_other());
			end
		end
		if (close_all)
			while (open_track.size() > 0)
				stmt_kinds.insert(stmt_kinds.size(), closer_for(take_last_open()));
	endtask

	task automatic send_statement(input bit with_start);
		foreach (stmt_kinds[i])
			put_token(stmt_kinds[i], with_start && i == 0, i == stmt_kinds.size() - 1);
	endtask

	// well-formed prefix, then the first bad closer, then tokens the block should ignore
	task automatic send_broken();
		tok_t c;
		build_balanced($urandom_range(0, 12), 6, 1'b0);
		if (open_track.size() == 0) begin
			stmt_kinds.insert(stmt_kinds.size(), random_closer());
		end else begin
			do c = random_closer(); while (c == closer_for(open_track[$]));
			stmt_kinds.insert(stmt_kinds.size(), c);
		end
		repeat ($urandom_range(0, 5))
			stmt_kinds.insert(stmt_kinds.size(), KIND_W'($urandom_range(0, 7)));
		send_statement(1'b1);
	endtask

	// fill the stack to its last entry, then either unwind or push one too many
	task automatic send_deep(input bit overflow);
		tok_t o;
		stmt_kinds.delete();
		open_track.delete();
		repeat (STACK_DEPTH) begin
			o = random_opener();
			open_track.insert(open_track.size(), o);
			stmt_kinds.insert(stmt_kinds.size(), o);
		end
		if (overflow) begin
			stmt_kinds.insert(stmt_kinds.size(), random_opener());
			repeat ($urandom_range(0, 3))
				stmt_kinds.insert(stmt_kinds.size(), KIND_W'($urandom_range(0, 7)));
		end else begin
			while (open_track.size() > 0)
				stmt_kinds.insert(stmt_kinds.size(), closer_for(take_last_open()));
		end
		send_statement(1'b1);
	endtask

	initial begin : stimulus
		int first_random;
		int r;
		int long_count;
		bit first;
		bit hold_done;
		bit pause_done;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single other token, unused code, each bracket pair
		put_token(TK_OTHER, 1'b1, 1'b1);
		put_token(KIND_UNUSED, 1'b1, 1'b1);
		put_token(TK_OPEN_SQUARE, 1'b1, 1'b0);
		put_token(TK_CLOSE_SQUARE, 1'b0, 1'b1);
		put_token(TK_OPEN_CURLY, 1'b1, 1'b0);
		put_token(TK_OPEN_ROUND, 1'b0, 1'b0);
		put_token(TK_CLOSE_ROUND, 1'b0, 1'b0);
		put_token(TK_CLOSE_CURLY, 1'b0, 1'b1);
		// stray closer on an empty stack
		put_token(TK_CLOSE_SQUARE, 1'b1, 1'b1);
		// wrong closer for each kind
		put_token(TK_OPEN_ROUND, 1'b1, 1'b0);
		put_token(TK_CLOSE_CURLY, 1'b0, 1'b1);
		put_token(TK_OPEN_CURLY, 1'b1, 1'b0);
		put_token(TK_CLOSE_SQUARE, 1'b0, 1'b1);
		put_token(TK_OPEN_SQUARE, 1'b1, 1'b0);
		put_token(TK_CLOSE_ROUND, 1'b0, 1'b1);
		// after an error the rest of the statement, its end mark too, is ignored
		put_token(TK_CLOSE_ROUND, 1'b1, 1'b0);
		put_token(TK_OPEN_ROUND, 1'b0, 1'b0);
		put_token(TK_CLOSE_SQUARE, 1'b0, 1'b1);
		// openers still open at the end pass as balanced
		put_token(TK_OPEN_ROUND, 1'b1, 1'b0);
		put_token(TK_OPEN_ROUND, 1'b0, 1'b1);
		// no start mark: the statement carries on past its end mark
		put_token(TK_OPEN_SQUARE, 1'b1, 1'b1);
		put_token(TK_CLOSE_SQUARE, 1'b0, 1'b1);
		wait_drained();

		// random part: mostly well-formed statements, some broken ones and noise
		first_random = items_sent;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			if (!hold_done && items_sent - first_random >= 15) begin
				// receiver sits still while one-token statements pour in
				hold_done = 1'b1;
				hold_req = 1'b1;
				gaps_on = 1'b0;
				repeat (30)
					put_token(KIND_W'($urandom_range(0, 7)), 1'b1, 1'b1);
				gaps_on = 1'b1;
			end
			if (!pause_done && items_sent - first_random >= 50) begin
				pause_done = 1'b1;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				build_balanced($urandom_range(1, 16), 8, $urandom_range(0, 3) != 0);
				send_statement(1'b1);
			end else if (r < 72) begin
				send_broken();
			end else if (r < 82) begin
				build_balanced($urandom_range(1, 10), 4, 1'b1);
				send_statement(1'b0);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 6))
					put_token(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 2) == 0,
						$urandom_range(0, 2) == 0);
			end else begin
				send_deep(r >= 96);
			end
		end

		// one statement long enough to saturate the token index, split by end marks
		long_count = 0;
		first = 1'b1;
		while (long_count < 980) begin
			build_balanced($urandom_range(4, 30), 6, 1'b1);
			foreach (stmt_kinds[i])
				put_token(stmt_kinds[i], first && i == 0, i == stmt_kinds.size() - 1);
			first = 1'b0;
			long_count += stmt_kinds.size();
		end
		put_token(TK_OPEN_SQUARE, 1'b0, 1'b0);
		repeat (1030 - long_count)
			put_token(TK_OTHER, 1'b0, 1'b0);
		put_token(TK_CLOSE_CURLY, 1'b0, 1'b1);

		// let the last results out, then wait for anything stray
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_bracket_balance_checker_top: clean");
		else
			$display("tb_bracket_balance_checker_top: errors");
		$finish;
	end

endmodule
